### rtl/midi_to_cv_mono_converter_top_defines.svh
// Assertion macros shared by the converter RTL.
// Included by files that carry concurrent checks; no dependencies.
`ifndef MIDI_TO_CV_MONO_CONVERTER_TOP_DEFINES_SVH
`define MIDI_TO_CV_MONO_CONVERTER_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define M2C_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define M2C_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/m2c_pkg.sv
// Shared types and constants for the MIDI-to-CV converter.
// No dependencies.
package m2c_pkg;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [6:0] CC_RESET_ALL = 7'h79;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_OFF   = 3'd1;
    localparam logic [2:0] OP_ON    = 3'd2;
    localparam logic [2:0] OP_RST   = 3'd3;
    localparam logic [2:0] OP_BEND  = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;

    // Classified command passed from the parser to the voice engine
    typedef struct packed {
        logic [2:0] op;
        logic [6:0] note;
        logic [6:0] vel;
        logic [9:0] bend;
    } cmd_t;

endpackage

### rtl/m2c_parser.sv
// Front end: MIDI byte parser with running status and SysEx skip.
// Depends on m2c_pkg.
module m2c_parser
    import m2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] listen_channel,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] midi_byte,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    logic [7:0] status_reg, status_next;
    logic [3:0] chan_reg, chan_next;
    logic       chan_ok_reg, chan_ok_next;
    logic [3:0] kind_reg, kind_next;
    logic       idx_reg, idx_next;
    logic       two_reg, two_next;
    logic [6:0] first_reg, first_next;
    logic       full_reg;
    cmd_t       cmd_reg, cmd_next;
    logic       take;
    logic [9:0] t;
    logic [12:0] t5;

    // one-entry queue toward the back end
    assign in_ready  = !full_reg || cmd_ready;
    assign take      = in_valid && in_ready;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;

    // bend target arithmetic: (1023 - (lsb/16 + msb*8)) * 5 / 32
    always_comb
    begin
        t  = 10'd1023 - ({midi_byte[6:0], 3'd0} + {7'd0, first_reg[6:4]});
        t5 = {3'd0, t} + {1'b0, t, 2'd0};
    end

    // classify
    always_comb
    begin
        status_next  = status_reg;
        chan_next    = chan_reg;
        chan_ok_next = chan_ok_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        two_next     = two_reg;
        first_next   = first_reg;
        cmd_next     = '0;
        cmd_next.op  = OP_NONE;
        if (mode)
        begin
            cmd_next.op = OP_TICK;
        end
        else if (status_reg == SYSEX_START)
        begin
            if (midi_byte == SYSEX_END)
                status_next = SYSEX_END;
        end
        else if (midi_byte > SYSEX_START)
        begin
            status_next = midi_byte;
            two_next = 1'b0;
            idx_next = 1'b0;
        end
        else if (midi_byte == SYSEX_START)
        begin
            status_next = SYSEX_START;
        end
        else if (midi_byte[7])
        begin
            status_next  = midi_byte;
            chan_next    = midi_byte[3:0];
            chan_ok_next = 1'b1;
            kind_next    = midi_byte[7:4];
            two_next     = !(midi_byte[7:4] == 4'hC || midi_byte[7:4] == 4'hD);
            idx_next     = 1'b0;
        end
        else if (!idx_reg && two_reg)
        begin
            first_next = midi_byte[6:0];
            idx_next   = 1'b1;
        end
        else
        begin
            idx_next = 1'b0;
            if (!idx_reg)
                first_next = midi_byte[6:0];
            if (status_reg < SYSEX_START && chan_ok_reg && chan_reg == listen_channel)
            begin
                cmd_next.note = idx_reg ? first_reg : midi_byte[6:0];
                cmd_next.vel  = midi_byte[6:0];
                cmd_next.bend = {2'd0, t5[12:5]};
                case (kind_reg)
                    4'h8: cmd_next.op = OP_OFF;
                    4'h9: cmd_next.op = (midi_byte[6:0] == 7'd0) ? OP_OFF : OP_ON;
                    4'hB: cmd_next.op = ((idx_reg ? first_reg : midi_byte[6:0]) == CC_RESET_ALL)
                                        ? OP_RST : OP_NONE;
                    4'hE: cmd_next.op = OP_BEND;
                    default: cmd_next.op = OP_NONE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= '0;
            chan_reg    <= '0;
            chan_ok_reg <= 1'b0;
            kind_reg    <= '0;
            idx_reg     <= 1'b0;
            two_reg     <= 1'b0;
            first_reg   <= '0;
            full_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                status_reg  <= status_next;
                chan_reg    <= chan_next;
                chan_ok_reg <= chan_ok_next;
                kind_reg    <= kind_next;
                idx_reg     <= idx_next;
                two_reg     <= two_next;
                first_reg   <= first_next;
            end
            if (take)
                full_reg <= 1'b1;
            else if (cmd_ready)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd_next;
    end

endmodule

### rtl/m2c_voice.sv
// Back end: sorted note table, pitch/gate and bend slew.
// Depends on m2c_pkg.
module m2c_voice
    import m2c_pkg::*;
#(
    parameter int NOTE_SLOTS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pitch_cv,
    output logic       gate,
    output logic [9:0] bend_cv
);

    localparam int CW = $clog2(NOTE_SLOTS + 1);
    localparam int IW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MOVE = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [6:0]    notes_reg [NOTE_SLOTS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] pos_reg;
    logic          found_reg;
    logic [1:0]    state_reg;
    cmd_t          cur_reg;
    logic [7:0]    pitch_reg;
    logic          gate_reg;
    logic [9:0]    target_reg;
    logic [9:0]    level_reg;
    logic          ovalid_reg;
    logic [6:0]    cur_note;
    logic [6:0]    top_now;
    logic [7:0]    pitch_now;
    logic [CW-1:0] newcnt;

    assign cmd_ready = (state_reg == ST_IDLE) && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;
    assign pitch_cv  = pitch_reg;
    assign gate      = gate_reg;
    assign bend_cv   = level_reg;

    assign cur_note  = notes_reg[k_reg[IW-1:0]];
    assign top_now   = notes_reg[0];
    assign pitch_now = (top_now > 7'd11) ? {top_now - 7'd11, 1'b0} : 8'd2;
    assign newcnt    = (count_reg == CW'(NOTE_SLOTS)) ? count_reg : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pitch_reg  <= 8'd255;
            gate_reg   <= 1'b0;
            target_reg <= 10'd512;
            level_reg  <= '0;
            ovalid_reg <= 1'b0;
            k_reg      <= '0;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        pos_reg   <= count_reg;
                        case (cmd.op)
                            OP_TICK:
                            begin
                                if (level_reg > target_reg)
                                    level_reg <= level_reg - 1'b1;
                                else if (level_reg < target_reg)
                                    level_reg <= level_reg + 1'b1;
                                state_reg <= ST_DONE;
                            end
                            OP_RST:
                            begin
                                count_reg  <= '0;
                                gate_reg   <= 1'b0;
                                target_reg <= 10'd512;
                                state_reg  <= ST_DONE;
                            end
                            OP_BEND:
                            begin
                                target_reg <= cmd.bend;
                                state_reg  <= ST_DONE;
                            end
                            OP_ON, OP_OFF: state_reg <= ST_SCAN;
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                // walk the table one slot per cycle
                ST_SCAN:
                begin
                    if (cur_reg.op == OP_OFF)
                    begin
                        if (k_reg >= count_reg)
                        begin
                            if (found_reg)
                            begin
                                count_reg <= count_reg - 1'b1;
                                if (count_reg == CW'(1))
                                    gate_reg <= 1'b0;
                                else
                                begin
                                    pitch_reg <= pitch_now;
                                end
                            end
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            if (found_reg)
                                notes_reg[k_reg[IW-1:0] - 1'b1] <= cur_note;
                            if (cur_note == cur_reg.note)
                                found_reg <= 1'b1;
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (k_reg >= count_reg)
                        begin
                            state_reg <= ST_MOVE;
                            k_reg <= newcnt - 1'b1;
                        end
                        else if (cur_note == cur_reg.note)
                        begin
                            pitch_reg <= pitch_now;
                            gate_reg  <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                        else if (cur_reg.note > cur_note)
                        begin
                            pos_reg   <= k_reg;
                            k_reg     <= newcnt - 1'b1;
                            state_reg <= ST_MOVE;
                        end
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                // shift down and insert, one slot per cycle
                ST_MOVE:
                begin
                    if (pos_reg >= CW'(NOTE_SLOTS))
                    begin
                        gate_reg  <= 1'b1;
                        pitch_reg <= pitch_now;
                        state_reg <= ST_DONE;
                    end
                    else if (k_reg > pos_reg)
                    begin
                        notes_reg[k_reg[IW-1:0]] <= notes_reg[k_reg[IW-1:0] - 1'b1];
                        k_reg <= k_reg - 1'b1;
                    end
                    else
                    begin
                        notes_reg[pos_reg[IW-1:0]] <= cur_reg.note;
                        count_reg <= newcnt;
                        found_reg <= 1'b1;
                        pos_reg   <= CW'(NOTE_SLOTS);
                    end
                end
                ST_DONE:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cur_reg <= cmd;
    end

endmodule

### rtl/midi_to_cv_mono_converter_top.sv
// MIDI-to-CV mono converter, high-note priority. Each word (a MIDI byte or a
// slew tick) gives one result word. The front parser classifies each byte into
// a registered command; the back engine walks the sorted note table one slot
// per cycle, so a note word takes longer there (table walk and shift) than
// other words.
// Depends on m2c_pkg, m2c_parser, m2c_voice and the shared defines header.
`include "midi_to_cv_mono_converter_top_defines.svh"
module midi_to_cv_mono_converter_top
    import m2c_pkg::*;
#(
    parameter int NOTE_SLOTS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] midi_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pitch_cv,
    output logic       gate,
    output logic [9:0] bend_cv
);

    logic [3:0] chan_reg;
    logic       cmd_valid;
    logic       cmd_ready;
    cmd_t       cmd;

    assign cfg_ready = 1'b1;

    // channel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chan_reg <= '0;
        else if (cfg_valid)
            chan_reg <= cfg_data;
    end

    m2c_parser u_parser (
        .clk(clk), .rst_n(rst_n), .listen_channel(chan_reg),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .midi_byte(midi_byte),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    m2c_voice #(.NOTE_SLOTS(NOTE_SLOTS)) u_voice (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
        .pitch_cv(pitch_cv), .gate(gate), .bend_cv(bend_cv)
    );

    `M2C_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bend_cv))
    `M2C_ASSERT_IMP(a_pitch_even, out_valid && gate, !pitch_cv[0])
    `M2C_ASSERT_NXT(a_bend_step, cmd_valid && cmd_ready, $stable(bend_cv) || $past(cmd.op) == OP_TICK)

endmodule
